/* src/wtok_pkg.sv */
`default_nettype none

package wtok_pkg;

  localparam int unsigned WORD_CAPACITY_DEF = 64;
  localparam logic [7:0]  MAX_WORDS_RST     = 8'd20;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_EXCL       = 8'h21;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_PERIOD     = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI   = 8'h39;
  localparam logic [7:0] CH_QUERY      = 8'h3F;
  localparam logic [7:0] CH_UPPER_LO   = 8'h41;
  localparam logic [7:0] CH_UPPER_HI   = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_LO   = 8'h61;
  localparam logic [7:0] CH_LOWER_HI   = 8'h7A;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_STR_END  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_out;
    logic [7:0] word_index;
    logic [5:0] char_pos;
    logic [7:0] tally;
  } res_t;

  // one queue slot holds every result of one input byte
  typedef struct packed {
    res_t first;
    res_t second;
    logic two;
  } slot_t;

  function automatic logic is_start(input logic [7:0] b);
    return (b >= CH_LOWER_LO && b <= CH_LOWER_HI) ||
           (b >= CH_UPPER_LO && b <= CH_UPPER_HI) ||
           (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) ||
           b == CH_UNDERSCORE || b == CH_SLASH;
  endfunction

  function automatic logic is_end(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_NUL;
  endfunction

  function automatic logic is_mark(input logic [7:0] b);
    return b == CH_PERIOD || b == CH_COMMA || b == CH_EXCL || b == CH_QUERY;
  endfunction

endpackage

`default_nettype wire

/* src/wtok_resq.sv */
`default_nettype none

module wtok_resq
  import wtok_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire slot_t slot_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output res_t       res_o,
  output logic       last_o
);

  slot_t             slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              sel_q, sel_d;
  slot_t             cur;
  logic              pop_res, pop_slot;

  assign cur         = slots_q[rd_q];
  assign out_valid_o = cnt_q != '0;
  assign full_o      = cnt_q == QCNT_W'(QDEPTH);
  assign res_o       = sel_q ? cur.second : cur.first;
  assign last_o      = !cur.two || sel_q;
  assign pop_res     = out_valid_o && !out_stall_i;
  assign pop_slot    = pop_res && last_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_slot ? rd_q + 1'b1 : rd_q;
    sel_d = pop_res ? !last_o : sel_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_slot);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      sel_q <= 1'b0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
      sel_q <= sel_d;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue over capacity");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full result queue");

  a_sel_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (out_valid_o && cur.two))
    else $error("second result selected in a single-result slot");

endmodule

`default_nettype wire

/* src/word_tokenizer_core.sv */
`default_nettype none

// channel   direction  handshake                    payload
// in        input      in_valid_i / in_stall_o      text_byte_i
// out       output     out_valid_o / out_stall_i    kind_o char_out_o word_index_o
//                                                   char_pos_o tally_o run_last_o
// cfg       input      max_words_we_i               max_words_i
//
// One byte is taken per cycle while in_stall_o is low; its zero, one or two results are
// decided in the same cycle and land in a four-slot result queue, read one result per
// cycle while out_stall_i is low; results reach the output through the queue registers.
// in_stall_o rises only when all four queue slots hold results not yet taken.
// Reset clears the word state, the queue and sets max_words to 20.

module word_tokenizer_core
  import wtok_pkg::*;
#(
  parameter int unsigned WORD_CAPACITY = WORD_CAPACITY_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       max_words_we_i,
  input  wire logic [7:0] max_words_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      char_out_o,
  output logic [7:0]      word_index_o,
  output logic [5:0]      char_pos_o,
  output logic [7:0]      tally_o,
  output logic            run_last_o
);

  localparam int unsigned      LEN_W   = $clog2(WORD_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_CAPACITY - 1);

  logic [7:0]       max_words_q;
  logic             inside_q, inside_d;
  logic             hold_q, hold_d;
  logic [7:0]       mark_q, mark_d;
  logic [LEN_W-1:0] kept_q, kept_d;
  logic [7:0]       words_q, words_d;

  logic             accept, full;
  logic [7:0]       b, words_inc;
  logic             e1, e2;
  logic [LEN_W-1:0] kept1;
  res_t             c1, c2;
  slot_t            slot;
  logic             push;
  res_t             res;

  function automatic res_t mk_char(input logic [7:0] ch, input logic [7:0] idx,
                                   input logic [LEN_W-1:0] pos);
    res_t r;
    r.kind       = KIND_CHAR;
    r.char_out   = ch;
    r.word_index = idx;
    r.char_pos   = 6'(pos);
    r.tally      = '0;
    return r;
  endfunction

  function automatic res_t mk_tally(input kind_e k, input logic [7:0] idx,
                                    input logic [7:0] t);
    res_t r;
    r.kind       = k;
    r.char_out   = '0;
    r.word_index = idx;
    r.char_pos   = '0;
    r.tally      = t;
    return r;
  endfunction

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = full;
  assign b         = text_byte_i;
  assign words_inc = words_q + 8'd1;

  always_comb begin
    inside_d    = inside_q;
    hold_d      = hold_q;
    mark_d      = mark_q;
    kept_d      = kept_q;
    words_d     = words_q;
    push        = 1'b0;
    e1          = 1'b0;
    e2          = 1'b0;
    kept1       = kept_q;
    c1          = mk_char(mark_q, words_q, kept_q);
    c2          = mk_char(b, words_q, kept_q);
    slot.first  = c2;
    slot.second = c2;
    slot.two    = 1'b0;

    if (inside_q) begin
      if (is_end(b)) begin
        push        = 1'b1;
        slot.first  = mk_tally(KIND_WORD_END, words_q, 8'(kept_q));
        slot.second = mk_tally(KIND_STR_END, 8'd0, words_inc);
        slot.two    = b == CH_NUL;
        inside_d    = 1'b0;
        hold_d      = 1'b0;
        mark_d      = '0;
        kept_d      = '0;
        words_d     = (b == CH_NUL) ? 8'd0 : words_inc;
      end else begin
        // held mark goes out first, then the new byte
        e1    = hold_q && (kept_q < LEN_MAX);
        kept1 = kept_q + LEN_W'(e1);
        c2    = mk_char(b, words_q, kept1);
        if (is_mark(b)) begin
          hold_d = 1'b1;
          mark_d = b;
        end else begin
          hold_d = 1'b0;
          mark_d = '0;
          e2     = kept1 < LEN_MAX;
        end
        kept_d      = kept1 + LEN_W'(e2);
        push        = e1 || e2;
        slot.first  = e1 ? c1 : c2;
        slot.second = c2;
        slot.two    = e1 && e2;
      end
    end else if (b == CH_NUL) begin
      push       = 1'b1;
      slot.first = mk_tally(KIND_STR_END, 8'd0, words_q);
      words_d    = '0;
      kept_d     = '0;
    end else if (is_start(b) && (words_q < max_words_q)) begin
      push       = 1'b1;
      slot.first = mk_char(b, words_q, '0);
      inside_d   = 1'b1;
      kept_d     = LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_words_q <= MAX_WORDS_RST;
      inside_q    <= 1'b0;
      hold_q      <= 1'b0;
      mark_q      <= '0;
      kept_q      <= '0;
      words_q     <= '0;
    end else begin
      if (max_words_we_i) begin
        max_words_q <= max_words_i;
      end
      if (accept) begin
        inside_q <= inside_d;
        hold_q   <= hold_d;
        mark_q   <= mark_d;
        kept_q   <= kept_d;
        words_q  <= words_d;
      end
    end
  end

  wtok_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && push),
    .slot_i      (slot),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .last_o      (run_last_o)
  );

  assign kind_o       = res.kind;
  assign char_out_o   = res.char_out;
  assign word_index_o = res.word_index;
  assign char_pos_o   = res.char_pos;
  assign tally_o      = res.tally;

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= LEN_MAX)
    else $error("kept length beyond word capacity");

  a_hold_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> inside_q)
    else $error("mark held outside a word");

  a_nul_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && b == CH_NUL) |=> (!inside_q && !hold_q && words_q == 8'd0 && kept_q == '0))
    else $error("string end did not clear word state");

endmodule

`default_nettype wire

/* dv/word_tokenizer_core_tb.sv */
`default_nettype none

module word_tokenizer_core_tb
  import wtok_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = WORD_CAPACITY_DEF;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] chr;
    logic [7:0] idx;
    logic [5:0] pos;
    logic [7:0] tally;
    logic       last;
  } token_t;

  typedef struct {
    logic [7:0] b;
    bit         wr_cfg;
    logic [7:0] cfg;
    bit         typed;
    token_t     want;
  } row_t;

  typedef enum {CL_START, CL_END, CL_MARK, CL_OTHER} char_class_e;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       max_words_we_i = 1'b0;
  logic [7:0] max_words_i    = 8'd0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte_i    = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] char_out_o;
  logic [7:0] word_index_o;
  logic [5:0] char_pos_o;
  logic [7:0] tally_o;
  logic       run_last_o;

  word_tokenizer_core #(.WORD_CAPACITY(CAP)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_words_we_i(max_words_we_i),
    .max_words_i   (max_words_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .char_out_o    (char_out_o),
    .word_index_o  (word_index_o),
    .char_pos_o    (char_pos_o),
    .tally_o       (tally_o),
    .run_last_o    (run_last_o)
  );

  // tokenizer shadow state
  logic [7:0] tk_max_words = MAX_WORDS_RST;
  bit         tk_in_word;
  bit         tk_holding;
  logic [7:0] tk_mark;
  int         tk_len;
  logic [7:0] tk_words = 8'd0;

  token_t byte_results[$];
  token_t pending_tokens[$];
  int     mismatch_count;
  int     busy_items;
  bit     tx_steady;
  bit     rx_steady;
  bit     rx_hold_req;

  row_t script [0:24] = '{
    '{8'h00,      0, 8'd0, 1, '{KIND_STR_END, 8'h00, 8'd0, 6'd0, 8'd0, 1'b1}},
    '{8'hFF,      0, 8'd0, 0, '0},
    '{"a",        0, 8'd0, 1, '{KIND_CHAR, "a", 8'd0, 6'd0, 8'd0, 1'b1}},
    '{8'hFF,      0, 8'd0, 1, '{KIND_CHAR, 8'hFF, 8'd0, 6'd1, 8'd0, 1'b1}},
    '{CH_PERIOD,  0, 8'd0, 0, '0},
    '{"Z",        0, 8'd0, 0, '0},
    '{CH_QUERY,   0, 8'd0, 0, '0},
    '{CH_SPACE,   0, 8'd0, 0, '0},
    '{"_",        0, 8'd0, 0, '0},
    '{CH_COMMA,   0, 8'd0, 0, '0},
    '{CH_NUL,     0, 8'd0, 0, '0},
    '{CH_SLASH,   0, 8'd0, 0, '0},
    '{CH_EXCL,    0, 8'd0, 0, '0},
    '{CH_EXCL,    0, 8'd0, 0, '0},
    '{CH_TAB,     0, 8'd0, 0, '0},
    '{"9",        0, 8'd0, 0, '0},
    '{CH_LF,      0, 8'd0, 0, '0},
    '{"-",        0, 8'd0, 0, '0},
    '{"0",        0, 8'd0, 0, '0},
    '{"x",        1, 8'd0, 0, '0},
    '{CH_SPACE,   0, 8'd0, 0, '0},
    '{"q",        0, 8'd0, 0, '0},
    '{CH_NUL,     0, 8'd0, 0, '0},
    '{"A",        0, 8'd0, 0, '0},
    '{CH_NUL,     0, 8'd0, 1, '{KIND_STR_END, 8'h00, 8'd0, 6'd0, 8'd0, 1'b1}}
  };

  function automatic char_class_e classify(input logic [7:0] b);
    if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_NUL) return CL_END;
    if (b == CH_PERIOD || b == CH_COMMA || b == CH_EXCL || b == CH_QUERY) return CL_MARK;
    if ((b >= CH_LOWER_LO && b <= CH_LOWER_HI) || (b >= CH_UPPER_LO && b <= CH_UPPER_HI) ||
        (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) || b == CH_UNDERSCORE || b == CH_SLASH)
      return CL_START;
    return CL_OTHER;
  endfunction

  function automatic void add_token(input kind_e k, input logic [7:0] c, input logic [7:0] i,
                                    input int p, input logic [7:0] t);
    if (byte_results.size() < 2) byte_results.push_back('{k, c, i, p[5:0], t, 1'b0});
  endfunction

  function automatic void keep_char(input logic [7:0] c);
    if (tk_len < CAP - 1) begin
      add_token(KIND_CHAR, c, tk_words, tk_len, 8'd0);
      tk_len++;
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b);
    char_class_e cls;
    cls = classify(b);
    byte_results.delete();
    if (tk_in_word) begin
      if (cls == CL_END) begin
        tk_holding = 1'b0;
        add_token(KIND_WORD_END, 8'd0, tk_words, 0, tk_len[7:0]);
        tk_words++;
        tk_in_word = 1'b0;
        tk_len = 0;
      end else begin
        if (tk_holding) begin
          tk_holding = 1'b0;
          keep_char(tk_mark);
        end
        if (cls == CL_MARK) begin
          tk_holding = 1'b1;
          tk_mark = b;
        end else begin
          keep_char(b);
        end
      end
    end else if (cls == CL_START && tk_words < tk_max_words) begin
      tk_in_word = 1'b1;
      tk_len = 0;
      keep_char(b);
    end
    if (b == CH_NUL) begin
      add_token(KIND_STR_END, 8'd0, 8'd0, 0, tk_words);
      tk_in_word = 1'b0;
      tk_holding = 1'b0;
      tk_len = 0;
      tk_words = 8'd0;
    end
    if (byte_results.size() != 0) byte_results[byte_results.size() - 1].last = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input token_t want = '0);
    int gap;
    int r;
    gap = 0;
    if (!tx_steady) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(5, 25);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tokenize_byte(b);
    if (typed) begin
      byte_results.delete();
      byte_results.push_back(want);
    end
    busy_items++;
    foreach (byte_results[k]) pending_tokens.push_back(byte_results[k]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] v);
    drain();
    max_words_we_i <= 1'b1;
    max_words_i    <= v;
    @(posedge clk_i);
    max_words_we_i <= 1'b0;
    tk_max_words = v;
  endtask

  function automatic logic [7:0] start_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return CH_LOWER_LO + r[7:0];
    if (r < 52) return CH_UPPER_LO + 8'(r - 26);
    if (r < 62) return CH_DIGIT_LO + 8'(r - 52);
    return (r == 62) ? CH_UNDERSCORE : CH_SLASH;
  endfunction

  function automatic logic [7:0] mark_char();
    case ($urandom_range(0, 3))
      0: return CH_PERIOD;
      1: return CH_COMMA;
      2: return CH_EXCL;
      default: return CH_QUERY;
    endcase
  endfunction

  function automatic logic [7:0] gap_char();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] any_non_end();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (classify(b) == CL_END) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_text();
    logic [7:0] txt[$];
    int nw;
    int wl;
    int r;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      nw = $urandom_range(0, 8);
      repeat (nw) begin
        repeat ($urandom_range(0, 2)) begin
          r = $urandom_range(0, 9);
          if (r < 6) txt.push_back(gap_char());
          else if (r < 8) txt.push_back(mark_char());
          else txt.push_back(any_non_end());
        end
        wl = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        txt.push_back(start_char());
        repeat (wl - 1) begin
          r = $urandom_range(0, 19);
          if (r < 13) txt.push_back(start_char());
          else if (r < 17) txt.push_back(mark_char());
          else txt.push_back(any_non_end());
        end
        if ($urandom_range(0, 2) == 0) txt.push_back(mark_char());
        if ($urandom_range(0, 3) != 0) txt.push_back(gap_char());
      end
    end
    txt.push_back(CH_NUL);
    foreach (txt[k]) send_byte(txt[k]);
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // result sink: random stalls, one long hold-off on request
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        r = $urandom_range(0, 99);
        if (rx_hold_req) begin
          rx_hold_req = 1'b0;
          stall_left = 80;
        end else if (!rx_steady) begin
          if (r < 20) stall_left = $urandom_range(1, 2);
          else if (r < 23) stall_left = $urandom_range(6, 25);
        end
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    token_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_tokens.size() == 0) begin
          $display("%0t: result exp none got kind %0d char %h", $time, kind_o, char_out_o);
          mismatch_count++;
        end else begin
          want = pending_tokens.pop_front();
          if (kind_o !== want.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, want.kind, kind_o);
            mismatch_count++;
          end
          if (char_out_o !== want.chr) begin
            $display("%0t: char_out exp %h got %h", $time, want.chr, char_out_o);
            mismatch_count++;
          end
          if (word_index_o !== want.idx) begin
            $display("%0t: word_index exp %0d got %0d", $time, want.idx, word_index_o);
            mismatch_count++;
          end
          if (char_pos_o !== want.pos) begin
            $display("%0t: char_pos exp %0d got %0d", $time, want.pos, char_pos_o);
            mismatch_count++;
          end
          if (tally_o !== want.tally) begin
            $display("%0t: tally exp %0d got %0d", $time, want.tally, tally_o);
            mismatch_count++;
          end
          if (run_last_o !== want.last) begin
            $display("%0t: run_last exp %0d got %0d", $time, want.last, run_last_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    int waited;
    int strings;
    int r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) begin
      if (script[k].wr_cfg) write_limit(script[k].cfg);
      send_byte(script[k].b, script[k].typed, script[k].want);
    end

    // long sink hold-off while the source keeps pushing
    write_limit(8'd255);
    rx_hold_req = 1'b1;
    tx_steady = 1'b1;
    repeat (30) send_byte(start_char());
    send_byte(CH_NUL);
    tx_steady = 1'b0;
    drain();

    strings = 0;
    while (busy_items < 550) begin
      if (strings % 3 == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) write_limit(8'd0);
        else if (r < 25) write_limit(8'($urandom_range(1, 3)));
        else if (r < 35) write_limit(8'd255);
        else write_limit(8'($urandom_range(0, 255)));
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      send_text();
      strings++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_tokens.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_tokens.size() != 0) begin
      $display("%0t: results exp %0d more got none", $time, pending_tokens.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
src/wtok_pkg.sv
src/wtok_resq.sv
src/word_tokenizer_core.sv
dv/word_tokenizer_core_tb.sv
